FILE: src/ikvl_pkg.sv
// ----------------------------------------------------------------------------
// ikvl_pkg
// Shared constants, operation and status codes and the memory request type
// for the positional key/value list.
// ----------------------------------------------------------------------------
package ikvl_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_W    = 32;
  localparam int VALUE_W  = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ENTRY_W  = KEY_W + VALUE_W;

  // Operation codes.
  localparam logic [1:0] CMD_GET    = 2'd0;
  localparam logic [1:0] CMD_SET    = 2'd1;
  localparam logic [1:0] CMD_INSERT = 2'd2;
  localparam logic [1:0] CMD_REMOVE = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // One write port and one read port of the entry memory.
  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [ADDR_W-1:0]  raddr;
  } mem_req_t;

endpackage

FILE: src/ikvl_entry_ram.sv
// ----------------------------------------------------------------------------
// ikvl_entry_ram
// Entry store: one key and one value per list position, one write port and
// one read port with registered read data.
// ----------------------------------------------------------------------------
module ikvl_entry_ram (
  input  logic                        clk_i,
  input  ikvl_pkg::mem_req_t          req_i,
  output logic [ikvl_pkg::ENTRY_W-1:0] rdata_o
);

  logic [ikvl_pkg::ENTRY_W-1:0] mem [ikvl_pkg::CAPACITY];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem[req_i.raddr];
  end

endmodule

FILE: src/ikvl_ctrl.sv
// ----------------------------------------------------------------------------
// ikvl_ctrl
// Sequencer: checks each request, drives the entry memory through the
// read, shift and write steps of the operation, and registers the result.
// ----------------------------------------------------------------------------
module ikvl_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    cmd_i,
  input  logic [ikvl_pkg::CNT_W-1:0]    index_i,
  input  logic [ikvl_pkg::KEY_W-1:0]    key_i,
  input  logic [ikvl_pkg::VALUE_W-1:0]  value_i,
  output ikvl_pkg::mem_req_t            mem_req_o,
  input  logic [ikvl_pkg::ENTRY_W-1:0]  mem_rdata_i,
  output logic                          result_valid_o,
  output logic [1:0]                    status_o,
  output logic [ikvl_pkg::KEY_W-1:0]    key_out_o,
  output logic [ikvl_pkg::VALUE_W-1:0]  value_out_o,
  output logic [ikvl_pkg::CNT_W-1:0]    count_o
);

  localparam int AW = ikvl_pkg::ADDR_W;
  localparam int CW = ikvl_pkg::CNT_W;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_READ    = 3'd1;
  localparam logic [2:0] S_INS     = 3'd2;
  localparam logic [2:0] S_INS_FIN = 3'd3;
  localparam logic [2:0] S_RM      = 3'd4;

  logic [2:0]                   state_q, state_d;
  logic [1:0]                   cmd_q, cmd_d;
  logic [AW-1:0]                idx_q, idx_d;
  logic [AW-1:0]                ptr_q, ptr_d;
  logic [ikvl_pkg::KEY_W-1:0]   key_q, key_d;
  logic [ikvl_pkg::VALUE_W-1:0] val_q, val_d;
  logic [CW-1:0]                count_q, count_d;
  logic                         rv_q, rv_d;
  logic [1:0]                   status_q, status_d;
  logic [ikvl_pkg::KEY_W-1:0]   kout_q, kout_d;
  logic [ikvl_pkg::VALUE_W-1:0] vout_q, vout_d;

  logic          idx_ok;
  logic [CW-1:0] count_m1;
  logic [CW-1:0] idx_p1;
  logic [CW-1:0] ptr_p1;

  assign count_m1 = count_q - CW'(1);
  assign idx_p1   = {1'b0, idx_q} + CW'(1);
  assign ptr_p1   = {1'b0, ptr_q} + CW'(1);
  assign idx_ok   = (cmd_i == ikvl_pkg::CMD_INSERT) ? (index_i <= count_q)
                                                    : (index_i < count_q);

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    idx_d     = idx_q;
    ptr_d     = ptr_q;
    key_d     = key_q;
    val_d     = val_q;
    count_d   = count_q;
    rv_d      = 1'b0;
    status_d  = status_q;
    kout_d    = kout_q;
    vout_d    = vout_q;
    mem_req_o = '{we: 1'b0, waddr: ptr_q, wdata: mem_rdata_i, raddr: ptr_q};

    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d = cmd_i;
          idx_d = index_i[AW-1:0];
          key_d = key_i;
          val_d = value_i;
          if (!idx_ok) begin
            rv_d     = 1'b1;
            status_d = ikvl_pkg::ST_RANGE;
            kout_d   = '0;
            vout_d   = '0;
          end else if (cmd_i == ikvl_pkg::CMD_INSERT &&
                       count_q == CW'(ikvl_pkg::CAPACITY)) begin
            rv_d     = 1'b1;
            status_d = ikvl_pkg::ST_FULL;
            kout_d   = '0;
            vout_d   = '0;
          end else if (cmd_i == ikvl_pkg::CMD_INSERT) begin
            if (index_i < count_q) begin
              // Start moving the tail up, last entry first.
              mem_req_o.raddr = count_m1[AW-1:0];
              ptr_d           = count_m1[AW-1:0];
              state_d         = S_INS;
            end else begin
              state_d = S_INS_FIN;
            end
          end else begin
            mem_req_o.raddr = index_i[AW-1:0];
            state_d         = S_READ;
          end
        end
      end

      S_INS: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = ptr_q + AW'(1);
        mem_req_o.wdata = mem_rdata_i;
        if (ptr_q != idx_q) begin
          mem_req_o.raddr = ptr_q - AW'(1);
          ptr_d           = ptr_q - AW'(1);
        end else begin
          state_d = S_INS_FIN;
        end
      end

      S_INS_FIN: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = idx_q;
        mem_req_o.wdata = {key_q, val_q};
        rv_d            = 1'b1;
        status_d        = ikvl_pkg::ST_OK;
        kout_d          = key_q;
        vout_d          = val_q;
        count_d         = count_q + CW'(1);
        state_d         = S_IDLE;
      end

      S_READ: begin
        kout_d   = mem_rdata_i[ikvl_pkg::ENTRY_W-1:ikvl_pkg::VALUE_W];
        vout_d   = mem_rdata_i[ikvl_pkg::VALUE_W-1:0];
        status_d = ikvl_pkg::ST_OK;
        if (cmd_q == ikvl_pkg::CMD_REMOVE) begin
          if (idx_p1 < count_q) begin
            mem_req_o.raddr = idx_p1[AW-1:0];
            ptr_d           = idx_p1[AW-1:0];
            state_d         = S_RM;
          end else begin
            rv_d    = 1'b1;
            count_d = count_m1;
            state_d = S_IDLE;
          end
        end else begin
          if (cmd_q == ikvl_pkg::CMD_SET) begin
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = idx_q;
            mem_req_o.wdata = {key_q, val_q};
          end
          rv_d    = 1'b1;
          state_d = S_IDLE;
        end
      end

      S_RM: begin
        // Close the gap: each entry moves down one place.
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = ptr_q - AW'(1);
        mem_req_o.wdata = mem_rdata_i;
        if (ptr_p1 < count_q) begin
          mem_req_o.raddr = ptr_p1[AW-1:0];
          ptr_d           = ptr_p1[AW-1:0];
        end else begin
          rv_d    = 1'b1;
          count_d = count_m1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    idx_q    <= idx_d;
    ptr_q    <= ptr_d;
    key_q    <= key_d;
    val_q    <= val_d;
    status_q <= status_d;
    kout_q   <= kout_d;
    vout_q   <= vout_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = rv_q;
  assign status_o       = status_q;
  assign key_out_o      = kout_q;
  assign value_out_o    = vout_q;
  assign count_o        = count_q;

endmodule

FILE: src/indexed_key_value_list_core.sv
// ----------------------------------------------------------------------------
// indexed_key_value_list_core
// Ordered list of up to 16 key/value entries with get, set, insert and
// remove by position.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low, and every request
// gives exactly one result, shown for a single cycle with result_valid_o
// high; the receiver cannot stall, so it must take the result in that cycle.
// A rejected request (index out of range, or insert into a full list) gives
// its result in the cycle after it is taken and leaves busy low. Get and set
// read the entry at the index, set also writes it, and give the result.
// Insert and remove at position p move the entries behind p one place per
// cycle through the single write port of the entry memory, so they take
// longer the nearer p is to the start of the list. The result fields hold
// their last value between strobes, but a remove loads them at its read step,
// ahead of its strobe. count_o is the number of entries after the most recent
// operation.
module indexed_key_value_list_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    cmd_i,
  input  logic [ikvl_pkg::CNT_W-1:0]    index_i,
  input  logic [ikvl_pkg::KEY_W-1:0]    key_i,
  input  logic [ikvl_pkg::VALUE_W-1:0]  value_i,
  output logic                          result_valid_o,
  output logic [1:0]                    status_o,
  output logic [ikvl_pkg::KEY_W-1:0]    key_out_o,
  output logic [ikvl_pkg::VALUE_W-1:0]  value_out_o,
  output logic [ikvl_pkg::CNT_W-1:0]    count_o
);

  // Memory request from the sequencer and registered read data back.
  ikvl_pkg::mem_req_t             mem_req;
  logic [ikvl_pkg::ENTRY_W-1:0]   mem_rdata;

  ikvl_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .index_i        (index_i),
    .key_i          (key_i),
    .value_i        (value_i),
    .mem_req_o      (mem_req),
    .mem_rdata_i    (mem_rdata),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .key_out_o      (key_out_o),
    .value_out_o    (value_out_o),
    .count_o        (count_o)
  );

  // Read data from the entry memory is only used at positions that have been
  // written, since every used read is bounded by the entry count.
  ikvl_entry_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

endmodule
